/* rtl/core/scmm_pkg.sv */
`default_nettype none

package scmm_pkg;

   localparam int DataWidth = 8;
   localparam int RamDepth  = 65536;

   typedef logic [1:0] op_type;
   localparam op_type OP_READ  = 2'd0;
   localparam op_type OP_STORE = 2'd1;
   localparam op_type OP_TICK  = 2'd2;

   typedef logic [1:0] ext_src_type;
   localparam ext_src_type EXT_NONE = 2'd0;
   localparam ext_src_type EXT_DSP  = 2'd1;
   localparam ext_src_type EXT_PORT = 2'd2;

   typedef logic [3:0] io_reg_type;
   localparam io_reg_type REG_TEST    = 4'h0;
   localparam io_reg_type REG_CONTROL = 4'h1;
   localparam io_reg_type REG_DSPADDR = 4'h2;
   localparam io_reg_type REG_DSPDATA = 4'h3;
   localparam io_reg_type REG_PORT0   = 4'h4;
   localparam io_reg_type REG_PORT1   = 4'h5;
   localparam io_reg_type REG_PORT2   = 4'h6;
   localparam io_reg_type REG_PORT3   = 4'h7;
   localparam io_reg_type REG_RAM8    = 4'h8;
   localparam io_reg_type REG_RAM9    = 4'h9;
   localparam io_reg_type REG_TARGET0 = 4'hA;
   localparam io_reg_type REG_TARGET1 = 4'hB;
   localparam io_reg_type REG_TARGET2 = 4'hC;
   localparam io_reg_type REG_OUT0    = 4'hD;
   localparam io_reg_type REG_OUT1    = 4'hE;
   localparam io_reg_type REG_OUT2    = 4'hF;

   localparam logic [11:0] IO_PAGE      = 12'h00F;
   localparam logic [9:0]  ROM_PAGE     = 10'h3FF;
   localparam logic [7:0]  SPEED_RESET  = 8'd24;
   localparam logic [1:0]  TIMER_NONE   = 2'd3;

   // access cost per TEST speed code, already scaled by 24/3
   localparam logic [7:0] SPEED_CYCLES [16] = '{
      8'd24,  8'd40,  8'd72,  8'd136, 8'd32,  8'd48,  8'd80,  8'd144,
      8'd48,  8'd64,  8'd96,  8'd160, 8'd80,  8'd96,  8'd128, 8'd192
   };

   localparam logic [7:0] BOOT_ROM [64] = '{
      8'hCD, 8'hEF, 8'hBD, 8'hE8, 8'h00, 8'hC6, 8'h1D, 8'hD0,
      8'hFC, 8'h8F, 8'hAA, 8'hF4, 8'h8F, 8'hBB, 8'hF5, 8'h78,
      8'hCC, 8'hF4, 8'hD0, 8'hFB, 8'h2F, 8'h19, 8'hEB, 8'hF4,
      8'hD0, 8'hFC, 8'h7E, 8'hF4, 8'hD0, 8'h0B, 8'hE4, 8'hF5,
      8'hCB, 8'hF4, 8'hD7, 8'h00, 8'hFC, 8'hD0, 8'hF3, 8'hAB,
      8'h01, 8'h10, 8'hEF, 8'h7E, 8'hF4, 8'h10, 8'hEB, 8'hBA,
      8'hF6, 8'hDA, 8'h00, 8'hBA, 8'hF4, 8'hC4, 8'hF4, 8'hDD,
      8'h5D, 8'hD0, 8'hDB, 8'h1F, 8'h00, 8'h00, 8'hC0, 8'hFF
   };

   typedef struct packed {
      logic [7:0]  read_data;
      ext_src_type external_source;
      logic [6:0]  external_index;
      logic        dsp_write_valid;
      logic        clear_ports_low;
      logic        clear_ports_high;
      logic [7:0]  access_cycles;
      logic [2:0]  timer_enables;
      logic [2:0]  timer_restart_mask;
      logic [1:0]  target_write_select;
      logic [7:0]  target_value;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/scmm_ram.sv */
`default_nettype none

module scmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     enable,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] address,
   input  wire logic [WIDTH-1:0]         write_data,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // read data holds until the next access
   always_ff @(posedge clock) begin
      if (enable) begin
         if (write_enable) begin
            mem[address] <= write_data;
         end
         read_data_ff <= mem[address];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

/* rtl/core/sound_cpu_memory_map_top.sv */
// Sound coprocessor bus decoder: 64 KiB RAM, boot ROM overlay at 0xFFC0-0xFFFF
// and the I/O page at 0x00F0-0x00FF.
// Requests come in on req_* (valid/ready): a byte read, a byte write or a timer
// tick. Each request yields exactly one result on rsp_* (valid/ready), in order.
// DSP and CPU-port reads take their byte from req_external_read_data of the
// same request; the port number or DSP address is reported in rsp_external_*.
// A request's RAM access (registered read) happens at its accept edge, together
// with the stage-1 register; the result register loads once it is free or taken.
// Throughput: one request per cycle while rsp_ready does not stall the result,
// set by the single RAM port that each request uses once.
// All control state (I/O registers, timer counts) updates at the accept edge,
// so back-to-back requests always see the effects of earlier ones.
// When rsp_ready is low, one request waits in the RAM stage and one in the
// result register; req_ready then drops until the result is taken.
// Reset (synchronous, active high) restores the I/O registers: boot ROM on,
// access cost at SPEED_RESET, timers off with zero counts. RAM is not cleared.
`default_nettype none

module sound_cpu_memory_map_top (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_write_data,
   input  wire logic        req_page_flag,
   input  wire logic [7:0]  req_external_read_data,
   input  wire logic [1:0]  req_timer_select,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_read_data,
   output logic [1:0]       rsp_external_source,
   output logic [6:0]       rsp_external_index,
   output logic             rsp_dsp_write_valid,
   output logic             rsp_clear_ports_low,
   output logic             rsp_clear_ports_high,
   output logic [7:0]       rsp_access_cycles,
   output logic [2:0]       rsp_timer_enables,
   output logic [2:0]       rsp_timer_restart_mask,
   output logic [1:0]       rsp_target_write_select,
   output logic [7:0]       rsp_target_value
);

   logic [7:0] dsp_ptr_ff, dsp_ptr_in;
   logic       boot_en_ff, boot_en_in;
   logic       io_dis_ff, io_dis_in;
   logic       ram_we_ff, ram_we_in;
   logic [7:0] speed_ff, speed_in;
   logic [2:0] tmr_en_ff, tmr_en_in;
   logic [3:0] tmr_count_ff [3];
   logic [3:0] tmr_count_in [3];

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_use_ram_ff, s1_use_ram_in;
   scmm_pkg::rsp_type     s1_ff, s1_in;
   logic                  out_valid_ff, out_valid_in;
   scmm_pkg::rsp_type     out_ff, out_in;

   logic                  accept;
   logic                  out_load;
   logic                  io_page;
   scmm_pkg::io_reg_type  io_reg;
   logic [1:0]            tsel;
   logic                  ram_store;
   logic [7:0]            ram_rdata;

   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign accept    = req_valid && req_ready;
   assign io_page   = (req_address[15:4] == scmm_pkg::IO_PAGE);
   assign io_reg    = req_address[3:0];

   scmm_ram #(
      .WIDTH(scmm_pkg::DataWidth),
      .DEPTH(scmm_pkg::RamDepth)
   ) u_ram (
      .clock       (clock),
      .enable      (accept),
      .write_enable(ram_store),
      .address     (req_address),
      .write_data  (req_write_data),
      .read_data   (ram_rdata)
   );

   always_comb begin
      dsp_ptr_in    = dsp_ptr_ff;
      boot_en_in    = boot_en_ff;
      io_dis_in     = io_dis_ff;
      ram_we_in     = ram_we_ff;
      speed_in      = speed_ff;
      tmr_en_in     = tmr_en_ff;
      tmr_count_in  = tmr_count_ff;
      tsel          = 2'd0;
      ram_store     = 1'b0;
      s1_use_ram_in = 1'b0;
      s1_in         = '0;

      if (accept) begin
         unique case (req_operation)
            scmm_pkg::OP_READ: begin
               if (!io_page) begin
                  if (req_address[15:6] == scmm_pkg::ROM_PAGE && boot_en_ff) begin
                     s1_in.read_data = scmm_pkg::BOOT_ROM[req_address[5:0]];
                  end else begin
                     s1_use_ram_in = 1'b1;
                  end
               end else begin
                  unique case (io_reg) inside
                     scmm_pkg::REG_DSPADDR: begin
                        s1_in.read_data = dsp_ptr_ff;
                     end
                     scmm_pkg::REG_DSPDATA: begin
                        s1_in.external_source = scmm_pkg::EXT_DSP;
                        s1_in.external_index  = dsp_ptr_ff[6:0];
                        s1_in.read_data       = req_external_read_data;
                     end
                     scmm_pkg::REG_PORT0, scmm_pkg::REG_PORT1,
                     scmm_pkg::REG_PORT2, scmm_pkg::REG_PORT3: begin
                        s1_in.external_source = scmm_pkg::EXT_PORT;
                        s1_in.external_index  = {5'd0, io_reg[1:0]};
                        s1_in.read_data       = req_external_read_data;
                     end
                     scmm_pkg::REG_RAM8, scmm_pkg::REG_RAM9: begin
                        s1_use_ram_in = 1'b1;
                     end
                     scmm_pkg::REG_OUT0, scmm_pkg::REG_OUT1, scmm_pkg::REG_OUT2: begin
                        // timer outputs clear on read
                        tsel = io_reg[1:0] - 2'd1;
                        s1_in.read_data    = {4'd0, tmr_count_ff[tsel]};
                        tmr_count_in[tsel] = 4'd0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            scmm_pkg::OP_STORE: begin
               if (!io_page) begin
                  ram_store = ram_we_ff;
               end else if (!io_dis_ff) begin
                  unique case (io_reg) inside
                     scmm_pkg::REG_TEST: begin
                        if (!req_page_flag) begin
                           speed_in  = scmm_pkg::SPEED_CYCLES[req_write_data[7:4]];
                           io_dis_in = req_write_data[2];
                           ram_we_in = req_write_data[1];
                        end
                     end
                     scmm_pkg::REG_CONTROL: begin
                        boot_en_in             = req_write_data[7];
                        s1_in.clear_ports_low  = req_write_data[4];
                        s1_in.clear_ports_high = req_write_data[5];
                        for (int t = 0; t < 3; t++) begin
                           if (req_write_data[t] && !tmr_en_ff[t]) begin
                              tmr_count_in[t]             = 4'd0;
                              s1_in.timer_restart_mask[t] = 1'b1;
                           end
                        end
                        tmr_en_in = req_write_data[2:0];
                     end
                     scmm_pkg::REG_DSPADDR: begin
                        dsp_ptr_in = req_write_data;
                     end
                     scmm_pkg::REG_DSPDATA: begin
                        // upper half of the DSP address space is read-only
                        if (!dsp_ptr_ff[7]) begin
                           s1_in.dsp_write_valid = 1'b1;
                           s1_in.external_index  = dsp_ptr_ff[6:0];
                        end
                     end
                     scmm_pkg::REG_PORT0, scmm_pkg::REG_PORT1,
                     scmm_pkg::REG_PORT2, scmm_pkg::REG_PORT3,
                     scmm_pkg::REG_RAM8, scmm_pkg::REG_RAM9: begin
                        ram_store = 1'b1;
                     end
                     scmm_pkg::REG_TARGET0, scmm_pkg::REG_TARGET1,
                     scmm_pkg::REG_TARGET2: begin
                        s1_in.target_write_select = 2'(io_reg - 4'd9);
                        s1_in.target_value        = req_write_data;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            scmm_pkg::OP_TICK: begin
               if (req_timer_select != scmm_pkg::TIMER_NONE) begin
                  tsel = req_timer_select;
                  if (tmr_en_ff[tsel]) begin
                     tmr_count_in[tsel] = tmr_count_ff[tsel] + 4'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      s1_in.access_cycles = speed_in;
      s1_in.timer_enables = tmr_en_in;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
         out_in       = s1_ff;
         if (s1_use_ram_ff) begin
            out_in.read_data = ram_rdata;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dsp_ptr_ff   <= 8'd0;
         boot_en_ff   <= 1'b1;
         io_dis_ff    <= 1'b0;
         ram_we_ff    <= 1'b1;
         speed_ff     <= scmm_pkg::SPEED_RESET;
         tmr_en_ff    <= 3'd0;
         tmr_count_ff <= '{default: 4'd0};
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         dsp_ptr_ff   <= dsp_ptr_in;
         boot_en_ff   <= boot_en_in;
         io_dis_ff    <= io_dis_in;
         ram_we_ff    <= ram_we_in;
         speed_ff     <= speed_in;
         tmr_en_ff    <= tmr_en_in;
         tmr_count_ff <= tmr_count_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff         <= s1_in;
         s1_use_ram_ff <= s1_use_ram_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_read_data           = out_ff.read_data;
   assign rsp_external_source     = out_ff.external_source;
   assign rsp_external_index      = out_ff.external_index;
   assign rsp_dsp_write_valid     = out_ff.dsp_write_valid;
   assign rsp_clear_ports_low     = out_ff.clear_ports_low;
   assign rsp_clear_ports_high    = out_ff.clear_ports_high;
   assign rsp_access_cycles       = out_ff.access_cycles;
   assign rsp_timer_enables       = out_ff.timer_enables;
   assign rsp_timer_restart_mask  = out_ff.timer_restart_mask;
   assign rsp_target_write_select = out_ff.target_write_select;
   assign rsp_target_value        = out_ff.target_value;

endmodule

`default_nettype wire

/* verif/tb_sound_cpu_memory_map_top.sv */
module tb_sound_cpu_memory_map_top;
   import scmm_pkg::*;

   localparam int RandomItems = 1000;
   localparam int LockTail    = 100;
   localparam int CycleLimit  = 300000;
   localparam int DrainCycles = 10;

   localparam op_type OP_UNUSED = 2'd3;

   // cost per bus access in cpu cycles, before scaling to the clock
   localparam logic [7:0] SPEED_BASE [16] = '{
      8'd3, 8'd5, 8'd9,  8'd17, 8'd4,  8'd6,  8'd10, 8'd18,
      8'd6, 8'd8, 8'd12, 8'd20, 8'd10, 8'd12, 8'd16, 8'd24
   };

   localparam logic [7:0] ROM_IMAGE [64] = '{
      8'hCD, 8'hEF, 8'hBD, 8'hE8, 8'h00, 8'hC6, 8'h1D, 8'hD0,
      8'hFC, 8'h8F, 8'hAA, 8'hF4, 8'h8F, 8'hBB, 8'hF5, 8'h78,
      8'hCC, 8'hF4, 8'hD0, 8'hFB, 8'h2F, 8'h19, 8'hEB, 8'hF4,
      8'hD0, 8'hFC, 8'h7E, 8'hF4, 8'hD0, 8'h0B, 8'hE4, 8'hF5,
      8'hCB, 8'hF4, 8'hD7, 8'h00, 8'hFC, 8'hD0, 8'hF3, 8'hAB,
      8'h01, 8'h10, 8'hEF, 8'h7E, 8'hF4, 8'h10, 8'hEB, 8'hBA,
      8'hF6, 8'hDA, 8'h00, 8'hBA, 8'hF4, 8'hC4, 8'hF4, 8'hDD,
      8'h5D, 8'hD0, 8'hDB, 8'h1F, 8'h00, 8'h00, 8'hC0, 8'hFF
   };

   typedef struct packed {
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  wdata;
      logic        pflag;
      logic [7:0]  ext;
      logic [1:0]  tsel;
   } bus_access_type;

   typedef struct {
      bus_access_type acc;
      bit             typed;
      rsp_type        want;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_READ;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic        req_page_flag = 1'b0;
   logic [7:0]  req_external_read_data = '0;
   logic [1:0]  req_timer_select = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_external_source;
   logic [6:0]  rsp_external_index;
   logic        rsp_dsp_write_valid;
   logic        rsp_clear_ports_low;
   logic        rsp_clear_ports_high;
   logic [7:0]  rsp_access_cycles;
   logic [2:0]  rsp_timer_enables;
   logic [2:0]  rsp_timer_restart_mask;
   logic [1:0]  rsp_target_write_select;
   logic [7:0]  rsp_target_value;

   // shadow of the bus decoder state
   logic [7:0]  bus_ram [RamDepth];
   bit          ram_written [RamDepth];
   logic [15:0] ram_addrs [$];
   logic [7:0]  dsp_ptr = 8'h00;
   logic        rom_on = 1'b1;
   logic        io_locked = 1'b0;
   logic        ram_wr_on = 1'b1;
   logic [7:0]  access_cost = SPEED_RESET;
   logic [2:0]  timer_on = 3'b000;
   logic [3:0]  out_count [3] = '{4'h0, 4'h0, 4'h0};

   rsp_type        pending_rsps [$];
   script_row_type script_rows [$];
   rsp_type        oldest_rsp;
   int             mismatches = 0;
   logic [15:0]    sink_cycle = '0;

   sound_cpu_memory_map_top i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bus_access_type mk_access(op_type op, logic [15:0] addr,
         logic [7:0] wdata, logic pflag, logic [7:0] ext, logic [1:0] tsel);
      bus_access_type a;
      a.op = op;
      a.addr = addr;
      a.wdata = wdata;
      a.pflag = pflag;
      a.ext = ext;
      a.tsel = tsel;
      return a;
   endfunction

   function automatic rsp_type mk_rsp(logic [7:0] rd, ext_src_type src, logic [6:0] idx,
         logic dspw, logic clo, logic chi, logic [7:0] cyc, logic [2:0] en,
         logic [2:0] rst, logic [1:0] tws, logic [7:0] twv);
      rsp_type r;
      r.read_data = rd;
      r.external_source = src;
      r.external_index = idx;
      r.dsp_write_valid = dspw;
      r.clear_ports_low = clo;
      r.clear_ports_high = chi;
      r.access_cycles = cyc;
      r.timer_enables = en;
      r.timer_restart_mask = rst;
      r.target_write_select = tws;
      r.target_value = twv;
      return r;
   endfunction

   function automatic rsp_type idle_rsp(logic [7:0] cyc, logic [2:0] en);
      return mk_rsp(8'h00, EXT_NONE, 7'h00, 1'b0, 1'b0, 1'b0, cyc, en, 3'b000, 2'd0, 8'h00);
   endfunction

   task automatic add_row(bus_access_type acc, bit typed, rsp_type want);
      script_row_type row;
      row.acc = acc;
      row.typed = typed;
      row.want = want;
      script_rows.push_back(row);
   endtask

   task automatic store_byte(logic [15:0] addr, logic [7:0] data);
      bus_ram[addr] = data;
      if (!ram_written[addr]) begin
         ram_written[addr] = 1'b1;
         ram_addrs.push_back(addr);
      end
   endtask

   // updates the shadow state and returns the result the block should give
   task automatic decode_access(input bus_access_type a, output rsp_type o);
      io_reg_type r;
      bit         io;
      int         t;
      o = '0;
      io = a.addr[15:4] == IO_PAGE;
      r = a.addr[3:0];
      case (a.op)
         OP_READ: begin
            if (!io) begin
               if (rom_on && a.addr[15:6] == ROM_PAGE) o.read_data = ROM_IMAGE[a.addr[5:0]];
               else o.read_data = bus_ram[a.addr];
            end else begin
               case (r)
                  REG_DSPADDR: o.read_data = dsp_ptr;
                  REG_DSPDATA: begin
                     o.external_source = EXT_DSP;
                     o.external_index = dsp_ptr[6:0];
                     o.read_data = a.ext;
                  end
                  REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3: begin
                     o.external_source = EXT_PORT;
                     o.external_index = 7'(r[1:0]);
                     o.read_data = a.ext;
                  end
                  REG_RAM8, REG_RAM9: o.read_data = bus_ram[a.addr];
                  REG_OUT0, REG_OUT1, REG_OUT2: begin
                     t = r - REG_OUT0;
                     o.read_data = {4'h0, out_count[t]};
                     out_count[t] = 4'h0;
                  end
                  default: ;
               endcase
            end
         end
         OP_STORE: begin
            if (!io) begin
               if (ram_wr_on) store_byte(a.addr, a.wdata);
            end else if (!io_locked) begin
               case (r)
                  REG_TEST: begin
                     if (!a.pflag) begin
                        access_cost = 8'(24 * SPEED_BASE[a.wdata[7:4]] / 3);
                        io_locked = a.wdata[2];
                        ram_wr_on = a.wdata[1];
                     end
                  end
                  REG_CONTROL: begin
                     rom_on = a.wdata[7];
                     o.clear_ports_low = a.wdata[4];
                     o.clear_ports_high = a.wdata[5];
                     for (t = 0; t < 3; t++) begin
                        if (a.wdata[t] && !timer_on[t]) begin
                           out_count[t] = 4'h0;
                           o.timer_restart_mask[t] = 1'b1;
                        end
                     end
                     timer_on = a.wdata[2:0];
                  end
                  REG_DSPADDR: dsp_ptr = a.wdata;
                  REG_DSPDATA: begin
                     // dsp registers above 0x7f are a read-only mirror
                     if (!dsp_ptr[7]) begin
                        o.dsp_write_valid = 1'b1;
                        o.external_index = dsp_ptr[6:0];
                     end
                  end
                  REG_PORT0, REG_PORT1, REG_PORT2, REG_PORT3, REG_RAM8, REG_RAM9:
                     store_byte(a.addr, a.wdata);
                  REG_TARGET0, REG_TARGET1, REG_TARGET2: begin
                     t = r - REG_TARGET0;
                     o.target_write_select = 2'(t + 1);
                     o.target_value = a.wdata;
                  end
                  default: ;
               endcase
            end
         end
         OP_TICK: begin
            if (a.tsel != TIMER_NONE && timer_on[a.tsel])
               out_count[a.tsel] = out_count[a.tsel] + 4'd1;
         end
         default: ;
      endcase
      o.access_cycles = access_cost;
      o.timer_enables = timer_on;
   endtask

   // random request; never reads a ram byte that was not written
   function automatic bus_access_type pick_access(bit lock_ok);
      bus_access_type a;
      int unsigned    kind;
      io_reg_type     r;
      a = mk_access(OP_READ, 16'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
         2'($urandom));
      r = 4'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         a.op = OP_STORE;
         case ($urandom_range(0, 3))
            0: ;
            1, 2: a.addr = 16'h0200 | 16'($urandom_range(0, 63));
            default: a.addr = {ROM_PAGE, 6'($urandom)};
         endcase
      end else if (kind < 55) begin
         if (ram_addrs.size() > 0 && $urandom_range(0, 3) != 0)
            a.addr = ram_addrs[$urandom_range(0, ram_addrs.size() - 1)];
         else
            a.addr = {ROM_PAGE, 6'($urandom)};
      end else if (kind < 75) begin
         a.op = OP_STORE;
         a.addr = {IO_PAGE, r};
         if (r == REG_TEST) begin
            a.wdata[2] = lock_ok && $urandom_range(0, 1) == 1;
            a.wdata[1] = $urandom_range(0, 3) != 0;
         end
      end else if (kind < 93) begin
         a.addr = {IO_PAGE, r};
      end else if (kind < 98) begin
         a.op = OP_TICK;
      end else begin
         a.op = OP_UNUSED;
      end
      // the write lock can only be undone by reset, so keep it for the tail
      if (a.op == OP_STORE && a.addr == {IO_PAGE, REG_TEST} && !lock_ok)
         a.wdata[2] = 1'b0;
      if (a.op == OP_READ && !ram_written[a.addr]) begin
         if (a.addr[15:4] == IO_PAGE ? a.addr[3:1] == 3'b100
               : !(rom_on && a.addr[15:6] == ROM_PAGE))
            a.addr = {IO_PAGE, REG_DSPADDR};
      end
      return a;
   endfunction

   task automatic send_access(bus_access_type a, bit typed, rsp_type want);
      rsp_type predicted;
      @(negedge clock);
      req_operation <= a.op;
      req_address <= a.addr;
      req_write_data <= a.wdata;
      req_page_flag <= a.pflag;
      req_external_read_data <= a.ext;
      req_timer_select <= a.tsel;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      decode_access(a, predicted);
      pending_rsps.push_back(typed ? want : predicted);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // receiver: always ready, mostly ready, mostly stalled, then a fixed duty pattern
   always @(negedge clock) begin
      sink_cycle <= sink_cycle + 16'd1;
      case (sink_cycle[9:8])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= $urandom_range(0, 3) != 0;
         2'd2: rsp_ready <= $urandom_range(0, 3) == 0;
         default: rsp_ready <= sink_cycle[2:0] < 3'd3;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $error("result with no request pending");
            mismatches++;
         end else begin
            oldest_rsp = pending_rsps.pop_front();
            check_field("read_data", oldest_rsp.read_data, rsp_read_data);
            check_field("external_source", oldest_rsp.external_source, rsp_external_source);
            check_field("external_index", oldest_rsp.external_index, rsp_external_index);
            check_field("dsp_write_valid", oldest_rsp.dsp_write_valid, rsp_dsp_write_valid);
            check_field("clear_ports_low", oldest_rsp.clear_ports_low, rsp_clear_ports_low);
            check_field("clear_ports_high", oldest_rsp.clear_ports_high,
               rsp_clear_ports_high);
            check_field("access_cycles", oldest_rsp.access_cycles, rsp_access_cycles);
            check_field("timer_enables", oldest_rsp.timer_enables, rsp_timer_enables);
            check_field("timer_restart_mask", oldest_rsp.timer_restart_mask,
               rsp_timer_restart_mask);
            check_field("target_write_select", oldest_rsp.target_write_select,
               rsp_target_write_select);
            check_field("target_value", oldest_rsp.target_value, rsp_target_value);
         end
      end
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("tb_sound_cpu_memory_map_top NOT OK");
      $finish;
   end

   initial begin
      int unsigned sent;
      bit          drained;
      logic [1:0]  run_timer;

      // boot rom image and reset values
      add_row(mk_access(OP_READ, 16'hFFC0, 8'h00, 1'b0, 8'h00, 2'd0), 1'b1,
         mk_rsp(8'hCD, EXT_NONE, 7'h00, 1'b0, 1'b0, 1'b0, 8'd24, 3'b000, 3'b000, 2'd0, 8'h00));
      add_row(mk_access(OP_READ, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 2'd3), 1'b1,
         mk_rsp(8'hFF, EXT_NONE, 7'h00, 1'b0, 1'b0, 1'b0, 8'd24, 3'b000, 3'b000, 2'd0, 8'h00));
      add_row(mk_access(OP_READ, {IO_PAGE, REG_OUT0}, 8'h00, 1'b0, 8'h00, 2'd0), 1'b1,
         idle_rsp(8'd24, 3'b000));
      add_row(mk_access(OP_STORE, 16'h0000, 8'h00, 1'b0, 8'h00, 2'd0), 1'b1,
         idle_rsp(8'd24, 3'b000));
      // writes under the rom overlay land in ram
      add_row(mk_access(OP_STORE, 16'hFFFF, 8'hA5, 1'b1, 8'hFF, 2'd3), 1'b1,
         idle_rsp(8'd24, 3'b000));
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_DSPADDR}, 8'h7F, 1'b0, 8'h00, 2'd0), 1'b1,
         idle_rsp(8'd24, 3'b000));
      add_row(mk_access(OP_READ, {IO_PAGE, REG_DSPDATA}, 8'h00, 1'b0, 8'h5A, 2'd0), 1'b1,
         mk_rsp(8'h5A, EXT_DSP, 7'h7F, 1'b0, 1'b0, 1'b0, 8'd24, 3'b000, 3'b000, 2'd0, 8'h00));
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_DSPDATA}, 8'h33, 1'b0, 8'h00, 2'd0), 1'b1,
         mk_rsp(8'h00, EXT_NONE, 7'h7F, 1'b1, 1'b0, 1'b0, 8'd24, 3'b000, 3'b000, 2'd0, 8'h00));
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_DSPADDR}, 8'h80, 1'b0, 8'h00, 2'd0), 1'b0, '0);
      // dsp mirror range ignores data writes
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_DSPDATA}, 8'h44, 1'b0, 8'h00, 2'd0), 1'b1,
         idle_rsp(8'd24, 3'b000));
      add_row(mk_access(OP_READ, {IO_PAGE, REG_PORT0}, 8'h00, 1'b0, 8'h00, 2'd0), 1'b1,
         mk_rsp(8'h00, EXT_PORT, 7'h00, 1'b0, 1'b0, 1'b0, 8'd24, 3'b000, 3'b000, 2'd0, 8'h00));
      add_row(mk_access(OP_READ, {IO_PAGE, REG_PORT3}, 8'h00, 1'b0, 8'hFF, 2'd0), 1'b1,
         mk_rsp(8'hFF, EXT_PORT, 7'h03, 1'b0, 1'b0, 1'b0, 8'd24, 3'b000, 3'b000, 2'd0, 8'h00));
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_CONTROL}, 8'hB7, 1'b0, 8'h00, 2'd0), 1'b1,
         mk_rsp(8'h00, EXT_NONE, 7'h00, 1'b0, 1'b1, 1'b1, 8'd24, 3'b111, 3'b111, 2'd0, 8'h00));
      add_row(mk_access(OP_TICK, 16'h0000, 8'h00, 1'b0, 8'h00, 2'd2), 1'b0, '0);
      add_row(mk_access(OP_TICK, 16'h0000, 8'h00, 1'b0, 8'h00, TIMER_NONE), 1'b0, '0);
      add_row(mk_access(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 2'd3), 1'b0, '0);
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_TARGET0}, 8'hFF, 1'b0, 8'h00, 2'd0), 1'b1,
         mk_rsp(8'h00, EXT_NONE, 7'h00, 1'b0, 1'b0, 1'b0, 8'd24, 3'b111, 3'b000, 2'd1, 8'hFF));
      add_row(mk_access(OP_READ, {IO_PAGE, REG_OUT2}, 8'h00, 1'b0, 8'h00, 2'd0), 1'b1,
         mk_rsp(8'h01, EXT_NONE, 7'h00, 1'b0, 1'b0, 1'b0, 8'd24, 3'b111, 3'b000, 2'd0, 8'h00));
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_CONTROL}, 8'h00, 1'b0, 8'h00, 2'd0), 1'b0, '0);
      add_row(mk_access(OP_READ, 16'hFFFF, 8'h00, 1'b0, 8'h00, 2'd0), 1'b0, '0);
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_TEST}, 8'hF0, 1'b1, 8'h00, 2'd0), 1'b0, '0);
      // slowest speed with ram writes off
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_TEST}, 8'hF0, 1'b0, 8'h00, 2'd0), 1'b1,
         idle_rsp(8'd192, 3'b000));
      add_row(mk_access(OP_STORE, 16'h0000, 8'h99, 1'b0, 8'h00, 2'd0), 1'b0, '0);
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_RAM9}, 8'hC3, 1'b0, 8'h00, 2'd0), 1'b0, '0);
      add_row(mk_access(OP_READ, 16'h0000, 8'h00, 1'b0, 8'h00, 2'd0), 1'b0, '0);
      add_row(mk_access(OP_READ, {IO_PAGE, REG_RAM9}, 8'h00, 1'b0, 8'h00, 2'd0), 1'b0, '0);
      add_row(mk_access(OP_STORE, {IO_PAGE, REG_TEST}, 8'h0A, 1'b0, 8'h00, 2'd0), 1'b0, '0);

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (script_rows[i])
         send_access(script_rows[i].acc, script_rows[i].typed, script_rows[i].want);

      sent = 0;
      drained = 1'b0;
      while (sent < RandomItems) begin
         // tick runs, at times long enough to wrap the 4-bit counters
         if ($urandom_range(0, 19) == 0) begin
            run_timer = 2'($urandom_range(0, 2));
            repeat ($urandom_range(10, 24)) begin
               send_access(mk_access(OP_TICK, 16'($urandom), 8'($urandom), 1'($urandom),
                  8'($urandom), run_timer), 1'b0, '0);
               sent++;
            end
         end
         repeat ($urandom_range(1, 16)) begin
            send_access(pick_access(sent + LockTail >= RandomItems), 1'b0, '0);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end
         if (!drained && sent >= RandomItems / 2) begin
            @(negedge clock) req_valid <= 1'b0;
            while (pending_rsps.size() != 0) @(negedge clock);
            drained = 1'b1;
         end
      end

      @(negedge clock) req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) $display("tb_sound_cpu_memory_map_top OK");
      else $display("tb_sound_cpu_memory_map_top NOT OK");
      $finish;
   end

endmodule
